// ===== rtl/wbcc_pkg.sv =====
package wbcc_pkg;

  localparam int ACC_W      = 25;
  localparam int BASE_W     = 3;
  localparam int QUAL_W     = 6;
  localparam int WEIGHT_W   = 17;
  localparam int MINCNT_W   = 8;
  localparam int NUM_BASES  = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int MUL_W      = ACC_W + 4;

  localparam int MAX_READS_DEF = 256;

  localparam logic [ACC_W-1:0]  ACC_MAX  = '1;
  localparam logic [BASE_W-1:0] BASE_GAP = BASE_W'(4);
  localparam logic              KIND_FOUNDER = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_CORR_EN    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRIEND_THR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT  = CFG_IDX_W'(2);

  localparam logic                 CORR_EN_RST    = 1'b1;
  localparam logic [WEIGHT_W-1:0]  FRIEND_THR_RST = WEIGHT_W'(32768);
  localparam logic [MINCNT_W-1:0]  MIN_COUNT_RST  = MINCNT_W'(3);

  typedef logic [NUM_BASES-1:0][ACC_W-1:0] totals_t;

  // accumulators of one finished position, handed to the decision stage
  typedef struct packed {
    totals_t             tot;
    logic [ACC_W-1:0]    sum;
    logic [BASE_W-1:0]   fbase;
    logic [QUAL_W-1:0]   fqual;
  } snap_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [WEIGHT_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + (ACC_W + 1)'(b);
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

endpackage

// ===== rtl/weighted_base_consensus_caller_core.sv =====
// Weighted majority consensus caller for one read position. Send a founder item (kind 0) with
// base and quality, then one read item (kind 1) per stacked read; the item with in_last high
// closes the position; the snapshot and output registers hold its result. One item is taken
// every cycle: each item costs one saturating update of the four base totals, the weight sum
// and the friend count in the accumulator registers, and the consensus decision for a closed
// position runs in its own stage behind them, so the next position starts at once. The input
// stalls only while a decided result is held by out_stall and another closed position waits.
// Configuration goes through the cfg port, which is always ready; write it only while no item
// is in flight, which the block itself does not enforce.
module weighted_base_consensus_caller_core #(
  parameter int MAX_READS = wbcc_pkg::MAX_READS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [wbcc_pkg::BASE_W-1:0]     in_base,
  input  logic [wbcc_pkg::QUAL_W-1:0]     in_qual,
  input  logic [wbcc_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [wbcc_pkg::BASE_W-1:0]     out_called_base,
  output logic [wbcc_pkg::QUAL_W-1:0]     out_called_qual,
  output logic                            out_changed,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbcc_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_READS + 1);

  logic                            corr_en_r, corr_en_nxt;
  logic [wbcc_pkg::WEIGHT_W-1:0]   thr_r, thr_nxt;
  logic [wbcc_pkg::MINCNT_W-1:0]   min_cnt_r, min_cnt_nxt;
  logic                            snap_take;
  logic                            snap_vld;
  wbcc_pkg::snap_t                 snap;
  logic [CNT_W-1:0]                snap_cnt;

  assign cfg_ready = 1'b1;

  always_comb begin
    corr_en_nxt = corr_en_r;
    thr_nxt     = thr_r;
    min_cnt_nxt = min_cnt_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wbcc_pkg::CFG_CORR_EN:    corr_en_nxt = cfg_data[0];
        wbcc_pkg::CFG_FRIEND_THR: thr_nxt     = cfg_data[wbcc_pkg::WEIGHT_W-1:0];
        wbcc_pkg::CFG_MIN_COUNT:  min_cnt_nxt = cfg_data[wbcc_pkg::MINCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corr_en_r <= wbcc_pkg::CORR_EN_RST;
      thr_r     <= wbcc_pkg::FRIEND_THR_RST;
      min_cnt_r <= wbcc_pkg::MIN_COUNT_RST;
    end else begin
      corr_en_r <= corr_en_nxt;
      thr_r     <= thr_nxt;
      min_cnt_r <= min_cnt_nxt;
    end
  end

  wbcc_acc #(
    .MAX_READS (MAX_READS)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .in_base    (in_base),
    .in_qual    (in_qual),
    .in_weight  (in_weight),
    .in_last    (in_last),
    .in_stall   (in_stall),
    .friend_thr (thr_r),
    .snap_take  (snap_take),
    .snap_vld   (snap_vld),
    .snap       (snap),
    .snap_cnt   (snap_cnt)
  );

  wbcc_dec #(
    .MAX_READS (MAX_READS)
  ) u_dec (
    .clk             (clk),
    .rst_n           (rst_n),
    .snap_vld        (snap_vld),
    .snap            (snap),
    .snap_cnt        (snap_cnt),
    .snap_take       (snap_take),
    .corr_en         (corr_en_r),
    .min_count       (min_cnt_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_called_base (out_called_base),
    .out_called_qual (out_called_qual),
    .out_changed     (out_changed)
  );

endmodule

// ===== rtl/wbcc_acc.sv =====
module wbcc_acc #(
  parameter int MAX_READS = wbcc_pkg::MAX_READS_DEF,
  localparam int CNT_W = $clog2(MAX_READS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_kind,
  input  logic [wbcc_pkg::BASE_W-1:0]   in_base,
  input  logic [wbcc_pkg::QUAL_W-1:0]   in_qual,
  input  logic [wbcc_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                          in_last,
  output logic                          in_stall,
  input  logic [wbcc_pkg::WEIGHT_W-1:0] friend_thr,
  input  logic                          snap_take,
  output logic                          snap_vld,
  output wbcc_pkg::snap_t               snap,
  output logic [CNT_W-1:0]              snap_cnt
);

  wbcc_pkg::totals_t               tot_r, tot_nxt, tot_upd;
  logic [wbcc_pkg::ACC_W-1:0]      sum_r, sum_nxt, sum_upd;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt, cnt_upd;
  logic [wbcc_pkg::BASE_W-1:0]     fbase_r, fbase_nxt, fbase_upd;
  logic [wbcc_pkg::QUAL_W-1:0]     fqual_r, fqual_nxt, fqual_upd;
  logic                            snap_vld_r, snap_vld_nxt;
  wbcc_pkg::snap_t                 snap_r;
  logic [CNT_W-1:0]                snap_cnt_r;
  logic                            accept;
  logic                            founder;
  logic                            friend;

  assign in_stall = snap_vld_r & ~snap_take;
  assign accept   = in_valid & ~in_stall;
  assign founder  = (in_kind == wbcc_pkg::KIND_FOUNDER);
  assign friend   = ~founder && (in_base < wbcc_pkg::BASE_GAP) && (in_weight > friend_thr);

  always_comb begin
    for (int k = 0; k < wbcc_pkg::NUM_BASES; k++) begin
      if (founder) begin
        tot_upd[k] = '0;
      end else if (friend && in_base == wbcc_pkg::BASE_W'(k)) begin
        tot_upd[k] = wbcc_pkg::sat_add(tot_r[k], in_weight);
      end else begin
        tot_upd[k] = tot_r[k];
      end
    end
    if (founder) begin
      sum_upd   = '0;
      cnt_upd   = '0;
      fbase_upd = in_base;
      fqual_upd = in_qual;
    end else begin
      sum_upd   = friend ? wbcc_pkg::sat_add(sum_r, in_weight) : sum_r;
      cnt_upd   = (friend && cnt_r < CNT_W'(MAX_READS)) ? cnt_r + CNT_W'(1) : cnt_r;
      fbase_upd = fbase_r;
      fqual_upd = fqual_r;
    end
  end

  always_comb begin
    tot_nxt      = tot_r;
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    fbase_nxt    = fbase_r;
    fqual_nxt    = fqual_r;
    snap_vld_nxt = snap_take ? 1'b0 : snap_vld_r;
    if (accept) begin
      fbase_nxt = fbase_upd;
      fqual_nxt = fqual_upd;
      if (in_last) begin
        tot_nxt      = '0;
        sum_nxt      = '0;
        cnt_nxt      = '0;
        snap_vld_nxt = 1'b1;
      end else begin
        tot_nxt = tot_upd;
        sum_nxt = sum_upd;
        cnt_nxt = cnt_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r      <= '0;
      sum_r      <= '0;
      cnt_r      <= '0;
      fbase_r    <= '0;
      fqual_r    <= '0;
      snap_vld_r <= 1'b0;
    end else begin
      tot_r      <= tot_nxt;
      sum_r      <= sum_nxt;
      cnt_r      <= cnt_nxt;
      fbase_r    <= fbase_nxt;
      fqual_r    <= fqual_nxt;
      snap_vld_r <= snap_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_last) begin
      snap_r.tot   <= tot_upd;
      snap_r.sum   <= sum_upd;
      snap_r.fbase <= fbase_upd;
      snap_r.fqual <= fqual_upd;
      snap_cnt_r   <= cnt_upd;
    end
  end

  assign snap_vld = snap_vld_r;
  assign snap     = snap_r;
  assign snap_cnt = snap_cnt_r;

`ifndef SYNTHESIS
  a_last_snaps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> snap_vld_r)
    else $error("last item did not reach the decision stage");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> sum_r == '0 && cnt_r == '0)
    else $error("accumulators not cleared after last item");

  a_sum_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r >= tot_r[0] && sum_r >= tot_r[1] && sum_r >= tot_r[2] && sum_r >= tot_r[3])
    else $error("base total exceeds weight sum");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_READS))
    else $error("friend count beyond limit");
`endif

endmodule

// ===== rtl/wbcc_dec.sv =====
module wbcc_dec #(
  parameter int MAX_READS = wbcc_pkg::MAX_READS_DEF,
  localparam int CNT_W = $clog2(MAX_READS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          snap_vld,
  input  wbcc_pkg::snap_t               snap,
  input  logic [CNT_W-1:0]              snap_cnt,
  output logic                          snap_take,
  input  logic                          corr_en,
  input  logic [wbcc_pkg::MINCNT_W-1:0] min_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wbcc_pkg::BASE_W-1:0]   out_called_base,
  output logic [wbcc_pkg::QUAL_W-1:0]   out_called_qual,
  output logic                          out_changed
);

  localparam int CMP_W = (CNT_W > wbcc_pkg::MINCNT_W) ? CNT_W : wbcc_pkg::MINCNT_W;

  logic [1:0]                      best_idx;
  logic [wbcc_pkg::ACC_W-1:0]      best_val;
  logic [wbcc_pkg::ACC_W-1:0]      second_val;
  logic [wbcc_pkg::MUL_W-1:0]      best10, sum7, second10, sum_ext;
  logic                            pass;
  logic [wbcc_pkg::BASE_W-1:0]     cb;
  logic [wbcc_pkg::QUAL_W-1:0]     cq;
  logic                            chg;
  logic                            out_valid_r, out_valid_nxt;
  logic [wbcc_pkg::BASE_W-1:0]     base_r;
  logic [wbcc_pkg::QUAL_W-1:0]     qual_r;
  logic                            changed_r;

  // lowest code wins a tie for best
  always_comb begin
    best_idx = 2'd0;
    for (int k = 1; k < wbcc_pkg::NUM_BASES; k++) begin
      if (snap.tot[k] > snap.tot[best_idx]) begin
        best_idx = 2'(k);
      end
    end
    best_val   = snap.tot[best_idx];
    second_val = '0;
    for (int k = 0; k < wbcc_pkg::NUM_BASES; k++) begin
      if (2'(k) != best_idx && snap.tot[k] > second_val) begin
        second_val = snap.tot[k];
      end
    end
  end

  always_comb begin
    best10   = (wbcc_pkg::MUL_W'(best_val) << 3) + (wbcc_pkg::MUL_W'(best_val) << 1);
    second10 = (wbcc_pkg::MUL_W'(second_val) << 3) + (wbcc_pkg::MUL_W'(second_val) << 1);
    sum_ext  = wbcc_pkg::MUL_W'(snap.sum);
    sum7     = (sum_ext << 3) - sum_ext;
    pass     = corr_en && (snap.sum != '0) &&
               (CMP_W'(snap_cnt) > CMP_W'(min_count)) &&
               (best10 > sum7) && (second10 < sum_ext);
    cb       = pass ? wbcc_pkg::BASE_W'(best_idx) : snap.fbase;
    chg      = (cb != snap.fbase);
    cq       = chg ? '0 : snap.fqual;
  end

  assign snap_take = ~out_valid_r | ~out_stall;

  always_comb begin
    out_valid_nxt = snap_take ? snap_vld : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_take && snap_vld) begin
      base_r    <= cb;
      qual_r    <= cq;
      changed_r <= chg;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_called_base = base_r;
  assign out_called_qual = qual_r;
  assign out_changed     = changed_r;

`ifndef SYNTHESIS
  a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
    snap_vld && snap_take |=> out_valid_r)
    else $error("decision taken but no result presented");

  a_changed_qual: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && changed_r |-> qual_r == '0)
    else $error("changed base carries nonzero quality");

  a_changed_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && changed_r |-> base_r < wbcc_pkg::BASE_GAP)
    else $error("changed base is not a real call");
`endif

endmodule

// ===== tb/consensus_call_checker.sv =====
module consensus_call_checker #(
  parameter int MAX_READS = wbcc_pkg::MAX_READS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_kind,
  input  logic [wbcc_pkg::BASE_W-1:0]     in_base,
  input  logic [wbcc_pkg::QUAL_W-1:0]     in_qual,
  input  logic [wbcc_pkg::WEIGHT_W-1:0]   in_weight,
  input  logic                            in_last,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [wbcc_pkg::BASE_W-1:0]     out_called_base,
  input  logic [wbcc_pkg::QUAL_W-1:0]     out_called_qual,
  input  logic                            out_changed,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wbcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbcc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_calls
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [wbcc_pkg::BASE_W-1:0] base;
    logic [wbcc_pkg::QUAL_W-1:0] qual;
    logic                        changed;
  } call_t;

  call_t expected_calls[$];

  logic                          corr_en;
  logic [wbcc_pkg::WEIGHT_W-1:0] friend_thr;
  logic [wbcc_pkg::MINCNT_W-1:0] min_friends;

  logic [wbcc_pkg::ACC_W-1:0]    base_tot [wbcc_pkg::NUM_BASES];
  logic [wbcc_pkg::ACC_W-1:0]    tot_sum;
  int unsigned                   friends;
  logic [wbcc_pkg::BASE_W-1:0]   fbase;
  logic [wbcc_pkg::QUAL_W-1:0]   fqual;

  int mismatches = 0;

  function automatic logic [wbcc_pkg::ACC_W-1:0] acc_add(logic [wbcc_pkg::ACC_W-1:0] acc,
                                                         logic [wbcc_pkg::WEIGHT_W-1:0] w);
    longint unsigned s;
    s = acc;
    s += w;
    return (s > wbcc_pkg::ACC_MAX) ? wbcc_pkg::ACC_MAX : s[wbcc_pkg::ACC_W-1:0];
  endfunction

  function automatic void clear_position();
    foreach (base_tot[k]) base_tot[k] = '0;
    tot_sum = '0;
    friends = 0;
  endfunction

  // majority decision on the closed position
  function automatic call_t call_position();
    int                         best;
    logic [wbcc_pkg::ACC_W-1:0] runner;
    call_t                      c;
    best = 0;
    runner = '0;
    for (int k = 1; k < wbcc_pkg::NUM_BASES; k++) begin
      if (base_tot[k] > base_tot[best]) best = k;
    end
    for (int k = 0; k < wbcc_pkg::NUM_BASES; k++) begin
      if (k != best && base_tot[k] > runner) runner = base_tot[k];
    end
    c.base = fbase;
    if (corr_en && tot_sum != '0 && friends > min_friends &&
        10 * longint'(base_tot[best]) > 7 * longint'(tot_sum) &&
        10 * longint'(runner) < longint'(tot_sum)) begin
      c.base = wbcc_pkg::BASE_W'(best);
    end
    c.changed = (c.base != fbase);
    c.qual = c.changed ? '0 : fqual;
    return c;
  endfunction

  always @(posedge clk) begin
    call_t want;
    if (!rst_n) begin
      corr_en = wbcc_pkg::CORR_EN_RST;
      friend_thr = wbcc_pkg::FRIEND_THR_RST;
      min_friends = wbcc_pkg::MIN_COUNT_RST;
      clear_position();
      fbase = '0;
      fqual = '0;
      expected_calls.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_calls.size() == 0) begin
          $error("result with no item pending: called_base %0d called_qual %0d changed %0d",
                 out_called_base, out_called_qual, out_changed);
          mismatches++;
        end else begin
          want = expected_calls.pop_front();
          if (out_called_base !== want.base) begin
            $error("called_base: expected %0d, actual %0d", want.base, out_called_base);
            mismatches++;
          end
          if (out_called_qual !== want.qual) begin
            $error("called_qual: expected %0d, actual %0d", want.qual, out_called_qual);
            mismatches++;
          end
          if (out_changed !== want.changed) begin
            $error("changed: expected %0d, actual %0d", want.changed, out_changed);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_kind == wbcc_pkg::KIND_FOUNDER) begin
          clear_position();
          fbase = in_base;
          fqual = in_qual;
        end else if (in_base < wbcc_pkg::NUM_BASES && in_weight > friend_thr) begin
          base_tot[in_base[1:0]] = acc_add(base_tot[in_base[1:0]], in_weight);
          tot_sum = acc_add(tot_sum, in_weight);
          if (friends < MAX_READS) friends++;
        end
        if (in_last) begin
          expected_calls.push_back(call_position());
          clear_position();
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wbcc_pkg::CFG_CORR_EN:    corr_en = cfg_data[0];
          wbcc_pkg::CFG_FRIEND_THR: friend_thr = cfg_data[wbcc_pkg::WEIGHT_W-1:0];
          wbcc_pkg::CFG_MIN_COUNT:  min_friends = cfg_data[wbcc_pkg::MINCNT_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending_calls <= expected_calls.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic                           KIND_READ   = ~wbcc_pkg::KIND_FOUNDER;
  localparam logic [wbcc_pkg::CFG_IDX_W-1:0] CFG_SPARE   = wbcc_pkg::CFG_IDX_W'(3);
  localparam int                             HOLD_CYCLES = 300;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_kind = 1'b0;
  logic [wbcc_pkg::BASE_W-1:0]     in_base = '0;
  logic [wbcc_pkg::QUAL_W-1:0]     in_qual = '0;
  logic [wbcc_pkg::WEIGHT_W-1:0]   in_weight = '0;
  logic                            in_last = 1'b0;
  logic                            out_stall = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [wbcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wbcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                            in_stall;
  logic                            out_valid;
  logic [wbcc_pkg::BASE_W-1:0]     out_called_base;
  logic [wbcc_pkg::QUAL_W-1:0]     out_called_qual;
  logic                            out_changed;
  logic                            cfg_ready;

  int fail_count;
  int pending_calls;

  int unsigned cur_thr = 32768;
  int          items_sent = 0;
  int          burst_left = 0;
  int          hold_seq = 0;

  weighted_base_consensus_caller_core u_dut (.*);

  consensus_call_checker u_checker (.*);

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: changing stall patterns, plus a long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    int seen;
    mode = 0;
    left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((left % 5) < 2);
      endcase
    end
  end

  task automatic offer(logic kind, logic [wbcc_pkg::BASE_W-1:0] base,
                       logic [wbcc_pkg::QUAL_W-1:0] qual,
                       logic [wbcc_pkg::WEIGHT_W-1:0] weight, logic last);
    in_valid <= 1'b1;
    in_kind <= kind;
    in_base <= base;
    in_qual <= qual;
    in_weight <= weight;
    in_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150) : $urandom_range(0, 20);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_calls != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic en, int unsigned thr, int unsigned min_cnt);
    logic [wbcc_pkg::CFG_IDX_W-1:0]  idxs [4];
    logic [wbcc_pkg::CFG_DATA_W-1:0] vals [4];
    settle();
    idxs = '{CFG_SPARE, wbcc_pkg::CFG_CORR_EN, wbcc_pkg::CFG_FRIEND_THR,
             wbcc_pkg::CFG_MIN_COUNT};
    vals[0] = wbcc_pkg::CFG_DATA_W'($urandom);
    vals[1] = {16'($urandom_range(0, 65535)), en};
    vals[2] = wbcc_pkg::CFG_DATA_W'(thr);
    vals[3] = {9'($urandom), wbcc_pkg::MINCNT_W'(min_cnt)};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    cur_thr = thr;
    @(posedge clk);
  endtask

  // weights clustered around the current threshold and at the extremes
  function automatic logic [wbcc_pkg::WEIGHT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    if (r < 15) return wbcc_pkg::WEIGHT_W'(cur_thr);
    if (r < 20) return wbcc_pkg::WEIGHT_W'(cur_thr + 1);
    if (r < 30) return wbcc_pkg::WEIGHT_W'($urandom_range(0, 131071));
    if (r < 40 && cur_thr > 0) return wbcc_pkg::WEIGHT_W'($urandom_range(0, cur_thr - 1));
    return wbcc_pkg::WEIGHT_W'($urandom_range(cur_thr + 1, 131071));
  endfunction

  task automatic send_position(int n_reads, int agree, bit heavy);
    logic [wbcc_pkg::BASE_W-1:0] dom;
    logic [wbcc_pkg::BASE_W-1:0] fb;
    logic [wbcc_pkg::BASE_W-1:0] rb;
    dom = wbcc_pkg::BASE_W'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) fb = wbcc_pkg::BASE_W'($urandom_range(0, 7));
    else fb = $urandom_range(0, 1) ? dom : wbcc_pkg::BASE_W'($urandom_range(0, 3));
    offer(wbcc_pkg::KIND_FOUNDER, fb, wbcc_pkg::QUAL_W'($urandom),
          wbcc_pkg::WEIGHT_W'($urandom), n_reads == 0);
    for (int i = 0; i < n_reads; i++) begin
      rb = ($urandom_range(0, 99) < agree) ? dom : wbcc_pkg::BASE_W'($urandom_range(0, 7));
      offer(KIND_READ, rb, wbcc_pkg::QUAL_W'($urandom), heavy ? '1 : pick_weight(),
            i == n_reads - 1);
    end
  endtask

  task automatic run_phase(int n_items);
    int stop;
    int n;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 4)) begin
            offer(1'($urandom), wbcc_pkg::BASE_W'($urandom), wbcc_pkg::QUAL_W'($urandom),
                  wbcc_pkg::WEIGHT_W'($urandom), $urandom_range(0, 2) == 0);
          end
        end
        1: send_position(0, 100, 1'b0);
        default: begin
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
          send_position(n, $urandom_range(50, 100), 1'b0);
        end
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reads before any founder use the reset founder
    repeat (3) offer(KIND_READ, 3'd1, '0, 17'd65536, 1'b0);
    offer(KIND_READ, 3'd1, '1, 17'd65536, 1'b1);
    // founder closing its own position, odd base code
    offer(wbcc_pkg::KIND_FOUNDER, 3'd7, 6'd63, '1, 1'b1);
    // weights at and just above threshold, gap and odd codes ignored
    offer(wbcc_pkg::KIND_FOUNDER, 3'd2, 6'd45, '0, 1'b0);
    repeat (4) offer(KIND_READ, 3'd2, '0, 17'd32769, 1'b0);
    offer(KIND_READ, 3'd3, '0, 17'd32768, 1'b0);
    offer(KIND_READ, wbcc_pkg::BASE_GAP, '0, 17'd65536, 1'b0);
    offer(KIND_READ, 3'd6, '0, '1, 1'b1);
    // full-scale weights flip the founder base
    offer(wbcc_pkg::KIND_FOUNDER, 3'd0, 6'd1, '0, 1'b0);
    repeat (3) offer(KIND_READ, 3'd3, '0, '1, 1'b0);
    offer(KIND_READ, 3'd3, '0, '1, 1'b1);
    // tie between two bases
    offer(wbcc_pkg::KIND_FOUNDER, 3'd3, 6'd20, '0, 1'b0);
    repeat (2) offer(KIND_READ, 3'd2, '0, 17'd40000, 1'b0);
    offer(KIND_READ, 3'd1, '0, 17'd40000, 1'b0);
    offer(KIND_READ, 3'd1, '0, 17'd40000, 1'b1);

    configure(1'b1, 32768, 3);
    hold_seq <= hold_seq + 1;
    repeat (12) send_position(0, 100, 1'b0);
    run_phase(50);

    configure(1'b1, 0, 0);
    run_phase(30);
    settle();
    run_phase(30);

    configure(1'b1, 65536, 0);
    run_phase(50);

    configure(1'b0, 16384, 1);
    hold_seq <= hold_seq + 1;
    repeat (10) send_position($urandom_range(0, 2), 100, 1'b0);
    run_phase(40);

    // friend count and accumulators saturate
    configure(1'b1, 1000, 255);
    send_position(262, 100, 1'b1);
    run_phase(20);

    configure(1'b1, $urandom_range(0, 65536), $urandom_range(0, 6));
    run_phase(60);

    configure(1'b1, $urandom_range(0, 65536), 2);
    run_phase(60);

    configure(1'b1, 32768, 3);
    run_phase(50);

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
